FILE: rtl/xcp_pkg.sv
`default_nettype none

package xcp_pkg;

  // largest supported side of the square image
  localparam int MAX_SIDE = 512;

  localparam int CFG_W   = 10;
  localparam int COUNT_W = 18;
  localparam int COL_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam int SIDE_RESET_I = (512 > MAX_SIDE) ? MAX_SIDE : 512;
  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(SIDE_RESET_I);

  // queue between the front and the back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // one classified pixel
  typedef struct packed {
    logic             px;
    logic [COL_W-1:0] col;
    logic             first_col;  // window restarts at column zero
    logic             check;      // window centers on an interior position
    logic             last;       // last pixel of the grid
  } item_t;

endpackage

`default_nettype wire

FILE: rtl/xcp_front.sv
`default_nettype none

module xcp_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [xcp_pkg::CFG_W-1:0]   cfg_wr_data,
  input  wire logic                        in_valid,
  input  wire logic                        in_pixel_is_x,
  input  wire logic                        q_full,
  output logic                             in_ready,
  output logic                             push,
  output xcp_pkg::item_t                   item
);
  import xcp_pkg::*;

  logic [SIDE_W-1:0] side_r, side_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [COL_W-1:0]  row_r, row_nxt;
  logic              col_end, row_end;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  assign col_end = ({1'b0, col_r} + 1'b1) >= side_r;
  assign row_end = ({1'b0, row_r} + 1'b1) >= side_r;

  always_comb begin
    item.px        = in_pixel_is_x;
    item.col       = col_r;
    item.first_col = (col_r == '0);
    item.check     = (row_r >= COL_W'(2)) && (col_r >= COL_W'(2));
    item.last      = col_end && row_end;
  end

  // clamp the written side to 1..MAX_SIDE
  always_comb begin
    side_nxt = side_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        side_nxt = SIDE_W'(1);
      end else if (int'(cfg_wr_data) > MAX_SIDE) begin
        side_nxt = SIDE_W'(MAX_SIDE);
      end else begin
        side_nxt = SIDE_W'(cfg_wr_data);
      end
      col_nxt = '0;
      row_nxt = '0;
    end else if (push) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_RESET;
      col_r  <= '0;
      row_r  <= '0;
    end else begin
      side_r <= side_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/xcp_fifo.sv
`default_nettype none

module xcp_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire xcp_pkg::item_t push_item,
  input  wire logic           pop,
  output logic                full,
  output logic                not_empty,
  output xcp_pkg::item_t      head
);
  import xcp_pkg::*;

  item_t             ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/xcp_back.sv
`default_nettype none

module xcp_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic                        q_not_empty,
  input  wire xcp_pkg::item_t              q_head,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [xcp_pkg::COUNT_W-1:0]      out_cross_count
);
  import xcp_pkg::*;

  // line store: bit 0 holds row r-1, bit 1 holds row r-2
  logic [1:0]         line_mem [MAX_SIDE];
  logic [1:0]         rdata_r;

  item_t              cur_r;
  logic               cur_v_r, cur_v_nxt;
  logic [8:0]         win_r, win_nxt;
  logic [COUNT_W-1:0] total_r, total_nxt, total_inc;
  logic               out_v_r, out_v_nxt;
  logic [COUNT_W-1:0] out_d_r;

  logic               out_busy, done, hit;
  logic [2:0]         col_bits;
  logic [8:0]         win_new;

  assign out_busy = out_v_r && !out_ready;
  assign done     = cur_v_r && !(cur_r.last && out_busy);
  assign pop      = q_not_empty && (!cur_v_r || done);

  assign col_bits = {cur_r.px, rdata_r[0], rdata_r[1]};
  assign win_new  = {col_bits, (cur_r.first_col ? 6'b0 : win_r[8:3])};
  // center plus four diagonal corners
  assign hit       = cur_r.check && win_new[0] && win_new[2] && win_new[4]
                     && win_new[6] && win_new[8];
  assign total_inc = (hit && total_r != COUNT_MAX) ? total_r + 1'b1 : total_r;

  always_comb begin
    cur_v_nxt = pop ? 1'b1 : (done ? 1'b0 : cur_v_r);
    win_nxt   = win_r;
    total_nxt = total_r;
    out_v_nxt = out_busy;
    if (cfg_wr_en) begin
      win_nxt   = '0;
      total_nxt = '0;
    end else if (done) begin
      win_nxt   = cur_r.last ? '0 : win_new;
      total_nxt = cur_r.last ? '0 : total_inc;
      if (cur_r.last) begin
        out_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rdata_r <= line_mem[q_head.col];
    end
    if (done) begin
      line_mem[cur_r.col] <= {rdata_r[0], cur_r.px};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_head;
    end
    if (done && cur_r.last) begin
      out_d_r <= total_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      win_r   <= '0;
      total_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      win_r   <= win_nxt;
      total_r <= total_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign out_valid       = out_v_r;
  assign out_cross_count = out_d_r;

endmodule

`default_nettype wire

FILE: rtl/x_cross_pattern_counter.sv
// Counts diagonal crosses in a square binary image streamed in raster order,
// one pixel per transfer; a cross is an interior pixel that is marked along
// with its four diagonal neighbours. After the last pixel of a grid the count
// appears as one output transfer and a new grid begins. Writing cfg_wr_data
// sets the side (0 acts as 1, values above 512 act as 512) and restarts the
// grid; write only while idle. One pixel per cycle is sustained: the front
// tags each pixel with its row and column flags, a four-entry queue decouples
// it from the back, which does one line-store read and one write per cycle
// through a single registered read port. A pixel goes from input transfer to
// a queue entry, then to the back's current register, where it is counted;
// the back stalls only while a finished count waits on out_ready. No
// clearing after reset is needed: unwritten line-store bits never count.
`default_nettype none

module x_cross_pattern_counter (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [xcp_pkg::CFG_W-1:0]   cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_pixel_is_x,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [xcp_pkg::COUNT_W-1:0]      out_cross_count
);
  import xcp_pkg::*;

  item_t front_item, q_head;
  logic  push, pop, q_full, q_not_empty;

  // pixel classification and position counters
  xcp_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_pixel_is_x (in_pixel_is_x),
    .q_full        (q_full),
    .in_ready      (in_ready),
    .push          (push),
    .item          (front_item)
  );

  // decoupling queue
  xcp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // line store, window and running total
  xcp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cross_count (out_cross_count)
  );

endmodule

`default_nettype wire
